### hw/rtl/afou_pkg.sv
// Shared types, constants and the divider step for the alpha flatten / unpremultiply pipe.
package afou_pkg;

  localparam logic [7:0]  CHAN_MAX   = 8'd255;
  localparam logic [15:0] HALF_ROUND = 16'd127;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FLATTEN_MODE     = 3'd0,
    REG_BACKGROUND_RED   = 3'd1,
    REG_BACKGROUND_GREEN = 3'd2,
    REG_BACKGROUND_BLUE  = 3'd3,
    REG_SOURCE_PREMULT   = 3'd4,
    REG_BLUE_FIRST       = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_FLAT,
    MODE_UNPREMULT
  } mode_t;

  typedef struct packed {
    logic       flatten_mode;
    logic [7:0] background_red;
    logic [7:0] background_green;
    logic [7:0] background_blue;
    logic       source_premultiplied;
    logic       blue_first;
  } cfg_t;

  typedef struct packed {
    logic  en1;
    logic  en2;
    logic  en3;
    mode_t mode2;
  } pipe_ctrl_t;

  typedef struct packed {
    logic [7:0] rem;
    logic       qbit;
  } div_step_t;

  // One restoring step; the result is valid only if rem is below den on entry.
  function automatic div_step_t div_step(input logic [7:0] rem, input logic nbit,
                                         input logic [7:0] den);
    logic [8:0] trial;
    div_step_t  r;
    trial = {rem, nbit};
    if (trial >= {1'b0, den}) begin
      r.rem  = 8'(trial - {1'b0, den});
      r.qbit = 1'b1;
    end else begin
      r.rem  = trial[7:0];
      r.qbit = 1'b0;
    end
    return r;
  endfunction

endpackage

### hw/rtl/afou_cfg.sv
// Configuration register file written through the plain write port.
module afou_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [afou_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [afou_pkg::CFG_DATA_W-1:0]  cfg_data,
  output afou_pkg::cfg_t                   cfg
);
  import afou_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FLATTEN_MODE:     cfg.flatten_mode         <= cfg_data[0];
        REG_BACKGROUND_RED:   cfg.background_red       <= cfg_data;
        REG_BACKGROUND_GREEN: cfg.background_green     <= cfg_data;
        REG_BACKGROUND_BLUE:  cfg.background_blue      <= cfg_data;
        REG_SOURCE_PREMULT:   cfg.source_premultiplied <= cfg_data[0];
        REG_BLUE_FIRST:       cfg.blue_first           <= cfg_data[0];
        default: ;
      endcase
    end
  end

endmodule

### hw/rtl/afou_chan.sv
// Three-stage datapath for one color channel: blend over background, un-premultiply, or pass through.
module afou_chan (
  input  logic                 clk,
  input  afou_pkg::pipe_ctrl_t ctrl,
  input  logic [7:0]           c,
  input  logic [7:0]           a,
  input  logic [7:0]           bg,
  input  logic [7:0]           a_s1,
  input  logic [7:0]           a_s2,
  output logic [7:0]           result
);
  import afou_pkg::*;

  // stage 1
  logic [15:0] fsum1;
  logic [7:0]  rem1;
  logic [7:0]  nlo1;
  logic        sat1;
  logic [7:0]  c1;
  // stage 2
  logic [7:0]  fq2;
  logic [7:0]  rem2;
  logic [3:0]  nlo2;
  logic [3:0]  qhi2;
  logic        sat2;
  logic [7:0]  c2;

  logic [15:0] prod_ca;
  logic [15:0] prod_bg;
  logic [15:0] numer;
  logic [15:0] fdiv;
  logic [7:0]  rem_hi [5];
  logic [3:0]  q_hi;
  logic [7:0]  rem_lo [5];
  logic [3:0]  q_lo;
  div_step_t   st_hi [4];
  div_step_t   st_lo [4];
  logic [7:0]  result_next;

  assign prod_ca = {8'd0, c} * {8'd0, a};
  assign prod_bg = {8'd0, bg} * {8'd0, CHAN_MAX - a};
  assign numer   = ({c, 8'd0} - {8'd0, c}) + {9'd0, a[7:1]};

  always_ff @(posedge clk) begin
    if (ctrl.en1) begin
      fsum1 <= prod_ca + prod_bg + HALF_ROUND;
      rem1  <= numer[15:8];
      nlo1  <= numer[7:0];
      sat1  <= (c >= a);
      c1    <= c;
    end
  end

  // x / 255 for x = fsum1, which never exceeds 65152
  assign fdiv = fsum1 + 16'd1 + {8'd0, fsum1[15:8]};

  always_comb begin
    rem_hi[0] = rem1;
    for (int i = 0; i < 4; i++) begin
      st_hi[i]     = div_step(rem_hi[i], nlo1[7-i], a_s1);
      rem_hi[i+1]  = st_hi[i].rem;
      q_hi[3-i]    = st_hi[i].qbit;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en2) begin
      fq2  <= fdiv[15:8];
      rem2 <= rem_hi[4];
      nlo2 <= nlo1[3:0];
      qhi2 <= q_hi;
      sat2 <= sat1;
      c2   <= c1;
    end
  end

  always_comb begin
    rem_lo[0] = rem2;
    for (int i = 0; i < 4; i++) begin
      st_lo[i]     = div_step(rem_lo[i], nlo2[3-i], a_s2);
      rem_lo[i+1]  = st_lo[i].rem;
      q_lo[3-i]    = st_lo[i].qbit;
    end
  end

  always_comb begin
    case (ctrl.mode2)
      MODE_FLAT:      result_next = fq2;
      MODE_UNPREMULT: result_next = sat2 ? CHAN_MAX : {qhi2, q_lo};
      MODE_PASS:      result_next = c2;
      default:        result_next = c2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.en3) begin
      result <= result_next;
    end
  end

endmodule

### hw/rtl/alpha_flatten_or_unpremultiply.sv
// Top level: config registers, pipeline control and three channel datapaths.
//
//  channel   signals                               direction
//  in        in_valid/in_ready, byte0..byte3       pixel into the block
//  out       out_valid/out_ready, out_byte0..3     processed pixel out
//  cfg       cfg_write, cfg_index, cfg_data        register writes, no wait
//
// Three register stages; one pixel per cycle sustained while out_ready stays high.
// The divider runs four restoring steps in each of stages two and three.
// Each stage has its own valid bit and loads when empty or when the next stage
// moves, so bubbles are squeezed out while the output waits for a transfer.
// Reset clears the valid bits and the config registers; data registers are not reset.
module alpha_flatten_or_unpremultiply (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      byte0,
  input  logic [7:0]                      byte1,
  input  logic [7:0]                      byte2,
  input  logic [7:0]                      byte3,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [7:0]                      out_byte0,
  output logic [7:0]                      out_byte1,
  output logic [7:0]                      out_byte2,
  output logic [7:0]                      out_byte3,
  input  logic                            cfg_write,
  input  logic [afou_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [afou_pkg::CFG_DATA_W-1:0] cfg_data
);
  import afou_pkg::*;

  cfg_t       cfg;
  pipe_ctrl_t ctrl;

  logic       v1, v2;
  logic       ready1, ready2, ready3;
  mode_t      mode0, mode1, mode2;
  logic [7:0] a1, a2;
  logic [7:0] bg0, bg2;

  afou_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign ready3   = !out_valid || out_ready;
  assign ready2   = !v2 || ready3;
  assign ready1   = !v1 || ready2;
  assign in_ready = ready1;

  always_comb begin
    if (cfg.flatten_mode) begin
      mode0 = MODE_FLAT;
    end else if (cfg.source_premultiplied && byte3 != 8'd0) begin
      mode0 = MODE_UNPREMULT;
    end else begin
      mode0 = MODE_PASS;
    end
  end

  assign bg0 = cfg.blue_first ? cfg.background_blue : cfg.background_red;
  assign bg2 = cfg.blue_first ? cfg.background_red  : cfg.background_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (ready1) v1 <= in_valid;
      if (ready2) v2 <= v1;
      if (ready3) out_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ready1) begin
      mode1 <= mode0;
      a1    <= byte3;
    end
    if (ready2) begin
      mode2 <= mode1;
      a2    <= a1;
    end
    if (ready3) begin
      out_byte3 <= (mode2 == MODE_FLAT) ? CHAN_MAX : a2;
    end
  end

  assign ctrl.en1   = ready1;
  assign ctrl.en2   = ready2;
  assign ctrl.en3   = ready3;
  assign ctrl.mode2 = mode2;

  afou_chan u_chan0 (
    .clk    (clk),
    .ctrl   (ctrl),
    .c      (byte0),
    .a      (byte3),
    .bg     (bg0),
    .a_s1   (a1),
    .a_s2   (a2),
    .result (out_byte0)
  );

  afou_chan u_chan1 (
    .clk    (clk),
    .ctrl   (ctrl),
    .c      (byte1),
    .a      (byte3),
    .bg     (cfg.background_green),
    .a_s1   (a1),
    .a_s2   (a2),
    .result (out_byte1)
  );

  afou_chan u_chan2 (
    .clk    (clk),
    .ctrl   (ctrl),
    .c      (byte2),
    .a      (byte3),
    .bg     (bg2),
    .a_s1   (a1),
    .a_s2   (a2),
    .result (out_byte2)
  );

endmodule
